// File: sv/hpr_pkg.sv
// Shared constants, codes and types of the hazard pointer reclaimer.
`default_nettype none
package hpr_pkg;

    localparam int NUM_RECS    = 8;
    localparam int HZP_PER_REC = 4;
    localparam int RLIST_DEPTH = 32;
    localparam int PTR_W       = 64;
    localparam int REC_W       = $clog2(NUM_RECS);
    localparam int SLOT_W      = $clog2(HZP_PER_REC);
    localparam int IDX_W       = $clog2(RLIST_DEPTH);
    localparam int CNT_W       = $clog2(RLIST_DEPTH + 1);
    localparam int NUM_SLOTS   = NUM_RECS * HZP_PER_REC;
    localparam int HAZ_W       = REC_W + SLOT_W;
    localparam int ADDR_W      = REC_W + IDX_W;
    localparam int RAM_DEPTH   = NUM_RECS * RLIST_DEPTH;
    localparam int CFG_IDX_W   = 2;

    localparam logic [2:0] REQ_ACQUIRE = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_SET     = 3'd2;
    localparam logic [2:0] REQ_RETIRE  = 3'd3;
    localparam logic [2:0] REQ_SCAN    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_SLOT    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT    = 2'd2;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [REC_W-1:0] rec_id;
        logic [1:0]       slot_index;
        logic [PTR_W-1:0] pointer_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [REC_W-1:0] granted_rec;
        logic             released_valid;
        logic [PTR_W-1:0] released_ptr;
        logic             last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_CHK,
        S_DEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic chk;
        logic dec;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic scan_go;
        logic scan_more;
        logic hit;
        logic pend_wait;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: sv/hazard_pointer_reclaimer_top.sv
// Top level of the hazard pointer reclaimer: controller, datapath and retire list RAM.
`default_nettype none
// The reclaimer takes one request item at a time and answers with one or more
// result items; the last one carries last = 1. Acquire, release and set go
// from acceptance through an execute step to the result item, as does a
// retire without a scan. A scan walks the caller's retire list through the
// retire list RAM entry by entry (read, compare against the in-use hazard
// slots of all records, decide); a freed entry is replaced by the list's
// last entry and checked again in place. Each freed pointer is reported as
// its own item when release_report is set, and a stalled output can hold
// the scan for as long as the consumer stalls. The configuration port is
// always ready and must only be written while idle.
module hazard_pointer_reclaimer_top
    import hpr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_req                 i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_result                   o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [5:0]           i_cfg_data
);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic             w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [PTR_W-1:0] w_ram_wdata;
    logic [ADDR_W-1:0] w_ram_raddr_a;
    logic [ADDR_W-1:0] w_ram_raddr_b;
    logic [PTR_W-1:0] w_ram_rdata_a;
    logic [PTR_W-1:0] w_ram_rdata_b;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    hpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hpr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_ram_we      (w_ram_we),
        .o_ram_waddr   (w_ram_waddr),
        .o_ram_wdata   (w_ram_wdata),
        .o_ram_raddr_a (w_ram_raddr_a),
        .o_ram_raddr_b (w_ram_raddr_b),
        .i_ram_rdata_a (w_ram_rdata_a),
        .i_ram_rdata_b (w_ram_rdata_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

    // Retire lists of all records, one row of RLIST_DEPTH entries per record.
    hpr_ram #(
        .WIDTH (PTR_W),
        .DEPTH (RAM_DEPTH)
    ) u_rlist_ram (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (w_ram_waddr),
        .i_wdata   (w_ram_wdata),
        .i_raddr_a (w_ram_raddr_a),
        .i_raddr_b (w_ram_raddr_b),
        .o_rdata_a (w_ram_rdata_a),
        .o_rdata_b (w_ram_rdata_b)
    );

endmodule
`default_nettype wire

// File: sv/hpr_ram.sv
// Generic single write, dual read RAM with registered read data.
`default_nettype none
module hpr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// File: sv/hpr_datapath.sv
// Datapath: record table, hazard slots, retire counts, scan compare and output register.
`default_nettype none
module hpr_datapath
    import hpr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_req                 i_in,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [5:0]           i_cfg_data,
    output logic                      o_ram_we,
    output logic [ADDR_W-1:0]         o_ram_waddr,
    output logic [PTR_W-1:0]          o_ram_wdata,
    output logic [ADDR_W-1:0]         o_ram_raddr_a,
    output logic [ADDR_W-1:0]         o_ram_raddr_b,
    input  wire logic [PTR_W-1:0]     i_ram_rdata_a,
    input  wire logic [PTR_W-1:0]     i_ram_rdata_b,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_result                   o_out
);

    t_req             r_req;
    logic [5:0]       r_thresh;
    logic [2:0]       r_slots_cfg;
    logic             r_report;
    logic [NUM_RECS-1:0] r_active;
    logic [PTR_W-1:0] r_haz [NUM_SLOTS];
    logic [CNT_W-1:0] r_cnt [NUM_RECS];
    logic [CNT_W-1:0] r_i;
    logic [1:0]       r_st;
    logic [REC_W-1:0] r_grant;
    logic [PTR_W-1:0] r_p;
    logic [PTR_W-1:0] r_lastv;
    logic [NUM_SLOTS-1:0] r_hit_vec;
    logic             r_pend_valid;
    logic [PTR_W-1:0] r_pend_ptr;
    logic             r_out_valid;
    t_result          r_out;

    logic [2:0]       w_used;
    logic [REC_W-1:0] w_rec;
    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_full;
    logic             w_found;
    logic [REC_W-1:0] w_free_rec;
    logic             w_hit;
    logic             w_out_free;
    logic             w_emit;
    t_result          w_emit_data;
    logic             w_retire_ok;

    assign w_used      = (r_slots_cfg > 3'(HZP_PER_REC)) ? 3'(HZP_PER_REC) : r_slots_cfg;
    assign w_rec       = r_req.rec_id;
    assign w_cnt       = r_cnt[w_rec];
    assign w_cnt_inc   = w_cnt + CNT_W'(1);
    assign w_full      = (w_cnt >= CNT_W'(RLIST_DEPTH));
    assign w_hit       = |r_hit_vec;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_retire_ok = (r_req.req_type == REQ_RETIRE) && !w_full;

    // Lowest-numbered inactive record.
    always_comb begin
        w_found    = 1'b0;
        w_free_rec = '0;
        for (int k = NUM_RECS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                w_found    = 1'b1;
                w_free_rec = REC_W'(k);
            end
        end
    end

    always_comb begin
        o_stat.scan_go   = (r_req.req_type == REQ_SCAN) ||
                           (w_retire_ok && ({1'b0, w_cnt_inc} >= {1'b0, r_thresh}));
        o_stat.scan_more = (r_i < w_cnt);
        o_stat.hit       = w_hit;
        o_stat.pend_wait = r_pend_valid && r_report && !w_out_free;
        o_stat.out_free  = w_out_free;
    end

    // Retire list memory accesses.
    always_comb begin
        o_ram_we      = 1'b0;
        o_ram_waddr   = {w_rec, w_cnt[IDX_W-1:0]};
        o_ram_wdata   = r_req.pointer_value;
        o_ram_raddr_a = {w_rec, r_i[IDX_W-1:0]};
        o_ram_raddr_b = {w_rec, w_cnt[IDX_W-1:0] - IDX_W'(1)};
        if (i_cmd.exec && w_retire_ok) begin
            o_ram_we = 1'b1;
        end else if (i_cmd.dec && !w_hit) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = {w_rec, r_i[IDX_W-1:0]};
            o_ram_wdata = r_lastv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= 6'd16;
            r_slots_cfg <= 3'd4;
            r_report    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thresh    <= i_cfg_data;
                CFG_SLOTS:     r_slots_cfg <= i_cfg_data[2:0];
                CFG_REPORT:    r_report    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) r_haz[k] <= '0;
            for (int k = 0; k < NUM_RECS; k++) r_cnt[k] <= '0;
            r_i      <= '0;
            r_st     <= ST_OK;
            r_grant  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_i     <= '0;
                r_st    <= ST_OK;
                r_grant <= '0;
            end
            if (i_cmd.exec) begin
                case (r_req.req_type)
                    REQ_ACQUIRE: begin
                        if (w_found) begin
                            r_active[w_free_rec] <= 1'b1;
                            r_grant              <= w_free_rec;
                        end else begin
                            r_st <= ST_NO_FREE;
                        end
                    end
                    REQ_RELEASE: begin
                        for (int s = 0; s < HZP_PER_REC; s++) begin
                            r_haz[{w_rec, SLOT_W'(s)}] <= '0;
                        end
                        r_active[w_rec] <= 1'b0;
                    end
                    REQ_SET: begin
                        if ({1'b0, r_req.slot_index} >= w_used) begin
                            r_st <= ST_SLOT;
                        end else begin
                            r_haz[{w_rec, r_req.slot_index[SLOT_W-1:0]}] <=
                                r_req.pointer_value;
                        end
                    end
                    REQ_RETIRE: begin
                        if (w_full) begin
                            r_st <= ST_FULL;
                        end else begin
                            r_cnt[w_rec] <= w_cnt_inc;
                            for (int s = 0; s < HZP_PER_REC; s++) begin
                                if ((s < int'(w_used)) &&
                                    (r_haz[{w_rec, SLOT_W'(s)}] == r_req.pointer_value)) begin
                                    r_haz[{w_rec, SLOT_W'(s)}] <= '0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.dec) begin
                if (w_hit) begin
                    r_i <= r_i + CNT_W'(1);
                end else begin
                    r_cnt[w_rec] <= w_cnt - CNT_W'(1);
                end
            end
        end
    end

    // Register the request; compare one retired entry against every in-use hazard slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else if (i_cmd.load) begin
            r_req <= i_in;
        end
        if (i_cmd.chk) begin
            r_p     <= i_ram_rdata_a;
            r_lastv <= i_ram_rdata_b;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_hit_vec[k] <= (r_haz[k] == i_ram_rdata_a) &&
                                ((k % HZP_PER_REC) < int'(w_used)) &&
                                (i_ram_rdata_a != '0);
            end
        end
    end

    always_comb begin
        w_emit                     = 1'b0;
        w_emit_data.status         = r_st;
        w_emit_data.granted_rec    = '0;
        w_emit_data.released_valid = 1'b1;
        w_emit_data.released_ptr   = r_pend_ptr;
        w_emit_data.last           = 1'b0;
        if (i_cmd.dec && !w_hit && r_report && r_pend_valid) begin
            w_emit = 1'b1;
        end else if (i_cmd.fin) begin
            w_emit           = 1'b1;
            w_emit_data.last = 1'b1;
            if (!r_pend_valid) begin
                w_emit_data.granted_rec    = r_grant;
                w_emit_data.released_valid = 1'b0;
                w_emit_data.released_ptr   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.dec && !w_hit && r_report) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.fin) begin
                r_pend_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec && !w_hit && r_report) begin
            r_pend_ptr <= r_p;
        end
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_index_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= w_cnt)
        else $error("scan index passed the retire count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CNT_W'(RLIST_DEPTH))
        else $error("retire count above list depth");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result item issued into a busy output register");

    a_free_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dec && !w_hit) |=> (w_cnt == $past(w_cnt) - CNT_W'(1)))
        else $error("freed entry did not shrink the retire list");
`endif

endmodule
`default_nettype wire

// File: sv/hpr_ctrl.sv
// Controller state machine sequencing requests and retire list scans.
`default_nettype none
module hpr_ctrl
    import hpr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = i_stat.scan_go ? S_RD : S_FIN;
            S_RD:   n_state = i_stat.scan_more ? S_CHK : S_FIN;
            S_CHK:  n_state = S_DEC;
            S_DEC:  if (i_stat.hit || !i_stat.pend_wait) n_state = S_RD;
            S_FIN:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_RD:   ;
            S_CHK:  o_cmd.chk = 1'b1;
            S_DEC:  o_cmd.dec = i_stat.hit || !i_stat.pend_wait;
            S_FIN:  o_cmd.fin = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire
